// ===== rtl/sorted_priority_queue_macros.svh =====
// Assertion helpers shared by the checker file.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted_priority_queue: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted_priority_queue: next-cycle check failed");

`endif

// ===== rtl/spq_pkg.sv =====
package spq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int PRIO_WIDTH = 16;
   localparam int CNT_WIDTH  = $clog2(DEPTH + 1);

   // port field widths
   localparam int REQ_DATA_W  = 32;
   localparam int REQ_PRIO_W  = 16;
   localparam int RSP_DATA_W  = 32;
   localparam int RSP_COUNT_W = 5;
   localparam int STATUS_W    = 2;

   // request kinds
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

   // command broadcast to every cell
   typedef struct packed {
      logic                  ins;
      logic                  rem;
      logic [DATA_WIDTH-1:0] data;
      logic [PRIO_WIDTH-1:0] prio;
   } ctrl_type;

endpackage

// ===== rtl/spq_cell.sv =====
module spq_cell (
   input  logic                           clock,
   input  spq_pkg::ctrl_type              ctrl,
   input  logic                           occupied,
   input  logic                           at_tail,
   input  logic                           prev_gt,
   input  logic [spq_pkg::DATA_WIDTH-1:0] prev_data,
   input  logic [spq_pkg::PRIO_WIDTH-1:0] prev_prio,
   input  logic [spq_pkg::DATA_WIDTH-1:0] next_data,
   input  logic [spq_pkg::PRIO_WIDTH-1:0] next_prio,
   output logic                           cell_gt,
   output logic [spq_pkg::DATA_WIDTH-1:0] cell_data,
   output logic [spq_pkg::PRIO_WIDTH-1:0] cell_prio
);

   logic [spq_pkg::DATA_WIDTH-1:0] data_ff, data_in;
   logic [spq_pkg::PRIO_WIDTH-1:0] prio_ff, prio_in;

   // held entry ranks below the incoming one: it moves one slot back
   assign cell_gt   = occupied && (prio_ff < ctrl.prio);
   assign cell_data = data_ff;
   assign cell_prio = prio_ff;

   always_comb begin
      data_in = data_ff;
      prio_in = prio_ff;
      priority if (ctrl.ins) begin
         if (prev_gt) begin
            data_in = prev_data;
            prio_in = prev_prio;
         end else if (cell_gt || at_tail) begin
            data_in = ctrl.data;
            prio_in = ctrl.prio;
         end
      end else if (ctrl.rem) begin
         data_in = next_data;
         prio_in = next_prio;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      prio_ff <= prio_in;
   end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue: holds up to spq_pkg::DEPTH entries in descending
// priority order, equal priorities in arrival order.
// Request channel (req_*): req_tuser selects insert (0) or remove (1);
// req_tdata carries the entry data and priority (ignored on remove).
// Response channel (rsp_*): exactly one word per request, carrying the
// popped data (zero unless a remove succeeded), the entry count after the
// request, and a status in rsp_tuser: ok, remove on empty, insert on full.
// A full insert is dropped; an empty remove changes nothing.
// Response: registered, valid the cycle after the request is accepted.
// Throughput: one request per cycle while the receiver takes each response
// word (see Stall). Every slot is a cell that compares its priority with the
// new one and shifts toward its neighbor in the same cycle, whatever the fill level.
// Stall: the response sits in an output register; while it waits, a new
// request is taken only in the cycle the receiver takes the old word
// (req_tready = !rsp_tvalid || rsp_tready).
// Reset (synchronous, active high) empties the queue and drops any pending
// response; slot contents are not cleared, the count alone marks them live.
module sorted_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // [31:0] entry_data, [47:32] entry_priority
   input  logic        req_tuser,  // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [31:0] front_data, [36:32] count_after, [39:37] zero
   output logic [1:0]  rsp_tuser   // [1:0] status
);

   localparam int N  = spq_pkg::DEPTH;
   localparam int CW = spq_pkg::CNT_WIDTH;
   localparam int DW = spq_pkg::DATA_WIDTH;
   localparam int PW = spq_pkg::PRIO_WIDTH;

   logic                  req_accept;
   logic                  is_full, q_empty;
   spq_pkg::ctrl_type     ctrl;

   logic [CW-1:0]         count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [spq_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [spq_pkg::RSP_COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [spq_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;

   // chain wiring
   logic [N-1:0]          occ, tail, gt;
   logic [DW-1:0]         cdata [N];
   logic [PW-1:0]         cprio [N];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign is_full = (count_ff == CW'(N));
   assign q_empty = (count_ff == '0);

   always_comb begin
      ctrl.ins  = req_accept && (req_tuser == spq_pkg::REQ_INSERT) && !is_full;
      ctrl.rem  = req_accept && (req_tuser == spq_pkg::REQ_REMOVE) && !q_empty;
      ctrl.data = req_tdata[DW-1:0];
      ctrl.prio = req_tdata[spq_pkg::REQ_DATA_W +: PW];
   end

   always_comb begin
      priority if (ctrl.ins) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.rem) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   // response built from the state before the update, with the count after it
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_count_in = spq_pkg::RSP_COUNT_W'(count_in);
         unique case (req_tuser)
            spq_pkg::REQ_INSERT: begin
               rsp_status_in = is_full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
            end
            spq_pkg::REQ_REMOVE: begin
               rsp_status_in = q_empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
               if (!q_empty) begin
                  rsp_data_in = spq_pkg::RSP_DATA_W'(cdata[0]);
               end
            end
            default: rsp_status_in = spq_pkg::ST_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_status_ff;

   // slot g is live below the count; the first free slot takes a tail insert
   always_comb begin
      for (int g = 0; g < N; g++) begin
         occ[g]  = CW'(g) < count_ff;
         tail[g] = CW'(g) == count_ff;
      end
   end

   for (genvar g = 0; g < N; g++) begin : g_cell
      logic          p_gt;
      logic [DW-1:0] p_data, n_data;
      logic [PW-1:0] p_prio, n_prio;

      if (g == 0) begin : g_head
         assign p_gt   = 1'b0;
         assign p_data = '0;
         assign p_prio = '0;
      end else begin : g_body
         assign p_gt   = gt[g-1];
         assign p_data = cdata[g-1];
         assign p_prio = cprio[g-1];
      end

      if (g == N - 1) begin : g_last
         // vacated on a remove, contents don't matter
         assign n_data = cdata[g];
         assign n_prio = cprio[g];
      end else begin : g_mid
         assign n_data = cdata[g+1];
         assign n_prio = cprio[g+1];
      end

      spq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (occ[g]),
         .at_tail   (tail[g]),
         .prev_gt   (p_gt),
         .prev_data (p_data),
         .prev_prio (p_prio),
         .next_data (n_data),
         .next_prio (n_prio),
         .cell_gt   (gt[g]),
         .cell_data (cdata[g]),
         .cell_prio (cprio[g])
      );
   end

endmodule

// ===== rtl/spq_checker.sv =====
`include "sorted_priority_queue_macros.svh"

module spq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // a stalled response word holds
   `SPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // no pending response means the queue takes a request
   `SPQ_ASSERT_NOW(a_ready_free, clock, reset, !rsp_tvalid, req_tready)

   // an accepted request always yields a response word next cycle
   `SPQ_ASSERT_NEXT(a_req_rsp, clock, reset, req_tvalid && req_tready, rsp_tvalid)

   // empty remove returns zero data and zero count
   `SPQ_ASSERT_NOW(a_empty, clock, reset, rsp_tvalid && (rsp_tuser == spq_pkg::ST_EMPTY), rsp_tdata == '0)

   // full insert reports a full count, no data, and no unused status code
   `SPQ_ASSERT_NOW(a_full, clock, reset, rsp_tvalid && (rsp_tuser != spq_pkg::ST_OK) && (rsp_tuser != spq_pkg::ST_EMPTY), (rsp_tuser == spq_pkg::ST_FULL) && (rsp_tdata[31:0] == '0) && (rsp_tdata[36:32] == 5'(spq_pkg::DEPTH)))

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);
